// ===== rtl/speed_pid_throttle_brake_step_core_assert.svh =====
// Assertion macros used by the bound checker in spd_pid_chk.sv.
`ifndef SPEED_PID_THROTTLE_BRAKE_STEP_CORE_ASSERT_SVH
`define SPEED_PID_THROTTLE_BRAKE_STEP_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SPD_PID_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define SPD_PID_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/spd_pid_pkg.sv =====
package spd_pid_pkg;

  localparam int GAIN_W = 16;
  localparam int ACC_W  = 52;
  localparam int CNT_W  = 4;

  // register indexes on the configuration port
  localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN    = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN    = 2'd2;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST     = 16'd5701;
  localparam logic [15:0] INTEG_GAIN_RST    = 16'd16370;
  localparam logic [15:0] DERIV_GAIN_RST    = 16'd0;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd1311;

  localparam logic [14:0] THROTTLE_FULL  = 15'd25600;
  localparam logic [15:0] THROTTLE_BASE  = 16'd25600;
  localparam logic [7:0]  SERVO_RELEASED = 8'd90;

  // floor(n/11) = (n * 2979) >> 15 for n below 32768
  localparam logic [11:0] DIV11_MUL = 12'd2979;
  // floor(n/10) = (n * 205) >> 11 for n up to 900
  localparam logic [7:0]  DIV10_MUL = 8'd205;

  typedef struct packed {
    logic load;  // clear the accumulator, capture the multipliers
    logic step;  // take one multiplier bit, MSB first
  } mac_ctl_t;

endpackage

// ===== rtl/spd_pid_if.sv =====
interface spd_pid_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_speed;
  logic signed [15:0] measured_speed;
  logic signed [15:0] brake_request;

  modport source (output valid, target_speed, measured_speed, brake_request, input ready);
  modport sink   (input valid, target_speed, measured_speed, brake_request, output ready);
endinterface

interface spd_pid_drive_if;
  logic               valid;
  logic               ready;
  logic        [14:0] throttle_pct;
  logic signed [15:0] brake_echo;
  logic        [7:0]  dac_high_code;
  logic        [7:0]  dac_low_code;
  logic        [7:0]  servo_angle;
  logic               braking;

  modport source (output valid, throttle_pct, brake_echo, dac_high_code, dac_low_code,
                  servo_angle, braking, input ready);
  modport sink   (input valid, throttle_pct, brake_echo, dac_high_code, dac_low_code,
                  servo_angle, braking, output ready);
endinterface

// ===== rtl/spd_pid_mac.sv =====
module spd_pid_mac (
  input  logic                                    clk,
  input  spd_pid_pkg::mac_ctl_t                   ctl,
  input  logic        [spd_pid_pkg::GAIN_W-1:0]   m0,
  input  logic        [spd_pid_pkg::GAIN_W-1:0]   m1,
  input  logic        [spd_pid_pkg::GAIN_W-1:0]   m2,
  input  logic signed [spd_pid_pkg::ACC_W-1:0]    x0,
  input  logic signed [spd_pid_pkg::ACC_W-1:0]    x1,
  input  logic signed [spd_pid_pkg::ACC_W-1:0]    x2,
  output logic signed [spd_pid_pkg::ACC_W-1:0]    acc
);
  import spd_pid_pkg::*;

  logic        [GAIN_W-1:0] sh0, sh1, sh2;
  logic signed [ACC_W-1:0]  acc_next;

  // Horner form: double, then add each operand whose multiplier bit is set
  always_comb begin
    acc_next = (acc <<< 1)
             + (sh0[GAIN_W-1] ? x0 : '0)
             + (sh1[GAIN_W-1] ? x1 : '0)
             + (sh2[GAIN_W-1] ? x2 : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh0 <= m0;
      sh1 <= m1;
      sh2 <= m2;
      acc <= '0;
    end else if (ctl.step) begin
      sh0 <= {sh0[GAIN_W-2:0], 1'b0};
      sh1 <= {sh1[GAIN_W-2:0], 1'b0};
      sh2 <= {sh2[GAIN_W-2:0], 1'b0};
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/speed_pid_throttle_brake_step_core.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+----------------------------------------------------------
// cmd      | in  | target_speed, measured_speed, brake_request (signed Q8.8)
// drive    | out | throttle_pct, brake_echo, dac_high_code, dac_low_code,
//          |     | servo_angle, braking
// cfg_*    | in  | write-only gain and sample-period registers
//
// Brake beats and beats with a non-positive error go from accept straight to
// the done state and then to the result register. A PID beat first runs one
// serial shift-add unit over the 16 bits of the sample period (integral
// increment), then over the 16 bits of the three gains at once, one bit per
// cycle. One beat is in work at a time; cmd.ready rises on the edge that
// loads the result and stays low during reset. Synchronous reset restores
// the register defaults and clears the integral and the last error. A stall
// on drive holds the result; the next cmd beat is taken meanwhile.
module speed_pid_throttle_brake_step_core (
  input logic        clk,
  input logic        rst,
  spd_pid_cmd_if.sink     cmd,
  spd_pid_drive_if.source drive,
  input logic        cfg_wen,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);
  import spd_pid_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULP  = 3'd1;
  localparam logic [2:0] ST_INTEG = 3'd2;
  localparam logic [2:0] ST_MULU  = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // configuration
  logic [15:0] prop_gain, integ_gain, deriv_gain, sample_period;

  // control
  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_valid;

  // controller state: integral is never negative, last error never negative
  logic [30:0] sum, sum_next;
  logic [14:0] prev;

  // per-beat work registers
  logic        [14:0] e_val;
  logic signed [16:0] de;
  logic signed [15:0] brake_reg;
  logic               brake_path;
  logic        [14:0] throttle;

  // output register
  logic        [14:0] o_throttle;
  logic signed [15:0] o_brake;
  logic        [7:0]  o_dac_high, o_dac_low, o_angle;
  logic               o_braking;

  logic               accept, load_out, last_bit;
  logic signed [16:0] diff;
  logic               e_pos, brake_pos;
  logic        [14:0] e_sat;
  logic        [31:0] sum_wide;
  logic        [31:0] quot;
  logic        [14:0] throttle_next;

  mac_ctl_t                mac_ctl;
  logic [GAIN_W-1:0]       m0, m1, m2;
  logic signed [ACC_W-1:0] x0, x1, x2, acc;

  function automatic logic [7:0] dac_high(input logic [14:0] t);
    logic [15:0] x;
    logic [19:0] a;
    logic [22:0] p;
    x = 16'(t) + THROTTLE_BASE;
    a = {x, 4'b0} + 20'(x);
    p = 23'(a[19:9]) * 23'(DIV11_MUL);
    return p[22:15];
  endfunction

  function automatic logic [7:0] dac_low(input logic [14:0] t);
    logic [15:0] x;
    logic [19:0] a;
    logic [22:0] p;
    x = 16'(t) + THROTTLE_BASE;
    a = {x, 4'b0} + 20'(x);
    p = 23'(a[19:10]) * 23'(DIV11_MUL);
    return p[22:15];
  endfunction

  // 90 + floor(percent * 90 / 100), percent = clamped brake in whole steps
  function automatic logic [7:0] servo_angle(input logic [14:0] b);
    logic [14:0] bc;
    logic [9:0]  n;
    logic [17:0] p;
    bc = (b > THROTTLE_FULL) ? THROTTLE_FULL : b;
    n  = 10'({bc[14:8], 3'b0}) + 10'(bc[14:8]);
    p  = 18'(n) * 18'(DIV10_MUL);
    return SERVO_RELEASED + 8'(p[17:11]);
  endfunction

  assign cmd.ready = (state == ST_IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign last_bit  = (cnt == CNT_W'(GAIN_W - 1));
  assign load_out  = (state == ST_DONE) && (!out_valid || drive.ready);

  // error, saturated to the positive 16-bit limit; only its sign matters below zero
  always_comb begin
    diff      = {cmd.target_speed[15], cmd.target_speed}
              - {cmd.measured_speed[15], cmd.measured_speed};
    e_pos     = !diff[16] && (diff != '0);
    e_sat     = diff[15] ? 15'h7fff : diff[14:0];
    brake_pos = !cmd.brake_request[15] && (cmd.brake_request != '0);
  end

  // integral update, saturating at the signed 32-bit limit
  always_comb begin
    sum_wide = {1'b0, sum} + 32'(acc[30:8]);
    sum_next = sum_wide[31] ? '1 : sum_wide[30:0];
  end

  // throttle = clamp(u >> 20, 0, 100 %)
  always_comb begin
    quot = acc[51:20];
    if (acc[ACC_W-1] || acc == '0) begin
      throttle_next = '0;
    end else if (quot > 32'(THROTTLE_FULL)) begin
      throttle_next = THROTTLE_FULL;
    end else begin
      throttle_next = quot[14:0];
    end
  end

  // serial unit: period * e first, then the three PID products together
  always_comb begin
    mac_ctl.load = (accept && !brake_pos && e_pos) || (state == ST_INTEG);
    mac_ctl.step = (state == ST_MULP) || (state == ST_MULU);
    if (state == ST_INTEG) begin
      m0 = prop_gain;
      m1 = integ_gain;
      m2 = deriv_gain;
    end else begin
      m0 = sample_period;
      m1 = '0;
      m2 = '0;
    end
    x0 = (state == ST_MULU) ? ACC_W'({e_val, 8'b0}) : ACC_W'(e_val);
    x1 = ACC_W'(sum);
    x2 = ACC_W'(signed'({de, 12'b0}));
  end

  spd_pid_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .m0  (m0),
    .m1  (m1),
    .m2  (m2),
    .x0  (x0),
    .x1  (x1),
    .x2  (x2),
    .acc (acc)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (brake_pos || !e_pos) ? ST_DONE : ST_MULP;
        end
      end
      ST_MULP: begin
        if (last_bit) begin
          state_next = ST_INTEG;
        end
      end
      ST_INTEG: state_next = ST_MULU;
      ST_MULU: begin
        if (last_bit) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: state_next = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
      prop_gain     <= PROP_GAIN_RST;
      integ_gain    <= INTEG_GAIN_RST;
      deriv_gain    <= DERIV_GAIN_RST;
      sample_period <= SAMPLE_PERIOD_RST;
      sum           <= '0;
      prev          <= '0;
    end else begin
      state <= state_next;

      // count multiplier bits; wraps back to zero after the last one
      if (mac_ctl.step) begin
        cnt <= cnt + 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (drive.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_wen) begin
        case (cfg_index)
          REG_PROP_GAIN:     prop_gain     <= cfg_data;
          REG_INTEG_GAIN:    integ_gain    <= cfg_data;
          REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
          REG_SAMPLE_PERIOD: sample_period <= cfg_data;
          default: ;
        endcase
      end

      // a non-positive error drops the integral and keeps the last error
      if (accept && !brake_pos && !e_pos) begin
        sum <= '0;
      end
      if (state == ST_INTEG) begin
        sum  <= sum_next;
        prev <= e_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      brake_reg  <= cmd.brake_request;
      brake_path <= brake_pos;
      e_val      <= e_sat;
      throttle   <= '0;
    end
    if (state == ST_INTEG) begin
      de <= {2'b0, e_val} - {2'b0, prev};
    end
    if (state == ST_CLAMP) begin
      throttle <= throttle_next;
    end
    if (load_out) begin
      o_throttle <= throttle;
      o_brake    <= brake_reg;
      o_dac_high <= dac_high(throttle);
      o_dac_low  <= dac_low(throttle);
      o_angle    <= brake_path ? servo_angle(brake_reg[14:0]) : SERVO_RELEASED;
      o_braking  <= brake_path;
    end
  end

  assign drive.valid         = out_valid;
  assign drive.throttle_pct  = o_throttle;
  assign drive.brake_echo    = o_brake;
  assign drive.dac_high_code = o_dac_high;
  assign drive.dac_low_code  = o_dac_low;
  assign drive.servo_angle   = o_angle;
  assign drive.braking       = o_braking;

endmodule

// ===== rtl/spd_pid_chk.sv =====
`include "speed_pid_throttle_brake_step_core_assert.svh"

module spd_pid_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        drive_valid,
  input logic        drive_ready,
  input logic [14:0] throttle_pct,
  input logic [7:0]  servo_angle,
  input logic        braking
);
  import spd_pid_pkg::*;

  // one beat in work at a time
  `SPD_PID_ASSERT_NXT(a_one_in_work, clk, rst, cmd_valid && cmd_ready, !cmd_ready)
  // braking forces zero throttle
  `SPD_PID_ASSERT_IMP(a_brake_no_throttle, clk, rst, drive_valid && braking, throttle_pct == '0)
  // the servo stays released off the brake path
  `SPD_PID_ASSERT_IMP(a_servo_released, clk, rst, drive_valid && !braking,
                      servo_angle == SERVO_RELEASED)
  // throttle never above full scale
  `SPD_PID_ASSERT_IMP(a_throttle_range, clk, rst, drive_valid, throttle_pct <= THROTTLE_FULL)
  // a stalled result holds
  `SPD_PID_ASSERT_NXT(a_drive_hold, clk, rst, drive_valid && !drive_ready,
                      drive_valid && $stable(throttle_pct))

endmodule

bind speed_pid_throttle_brake_step_core spd_pid_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .drive_valid  (drive.valid),
  .drive_ready  (drive.ready),
  .throttle_pct (drive.throttle_pct),
  .servo_angle  (drive.servo_angle),
  .braking      (drive.braking)
);

// ===== tb/speed_pid_throttle_brake_step_checker.sv =====
module speed_pid_throttle_brake_step_checker
  import spd_pid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  spd_pid_cmd_if      cmd,
  spd_pid_drive_if    drive,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          beats_pending
);

  localparam int unsigned DAC_SCALE    = 2550;
  localparam int unsigned DAC_DEN_HIGH = 844800;
  localparam int unsigned DAC_DEN_LOW  = 1689600;
  localparam int unsigned SERVO_SPAN   = 90;
  localparam int unsigned PCT_FULL     = 100;
  localparam int          ERR_MAX      = 32767;
  localparam int          ERR_MIN      = -32768;
  localparam longint      SUM_MAX      = 64'sd2147483647;

  typedef struct packed {
    logic [14:0]        throttle_pct;
    logic signed [15:0] brake_echo;
    logic [7:0]         dac_high_code;
    logic [7:0]         dac_low_code;
    logic [7:0]         servo_angle;
    logic               braking;
  } drive_beat_t;

  // shadow registers and controller state
  logic [15:0] prop_gain, integ_gain, deriv_gain, sample_period;
  int          integ_sum;
  int          prev_err;

  drive_beat_t drive_beats_due[$];

  function automatic logic [7:0] dac_code_for(input int unsigned thr, input int unsigned den);
    int unsigned code;
    code = ((THROTTLE_BASE + thr) * DAC_SCALE) / den;
    return (code > 255) ? 8'd255 : code[7:0];
  endfunction

  // Run one control step on the shadow state and return the drive beat it yields.
  function automatic drive_beat_t control_step(input logic signed [15:0] tgt,
                                               input logic signed [15:0] meas,
                                               input logic signed [15:0] brk);
    drive_beat_t r;
    int          err;
    int          derr;
    int unsigned thr;
    int unsigned brk_pct;
    longint      acc;
    longint      drive_sum;
    thr         = 0;
    r.servo_angle = SERVO_RELEASED;
    r.braking   = 1'b0;
    if (brk > 0) begin
      brk_pct = (brk > 25600) ? 25600 : int'(brk);
      r.servo_angle = 8'(SERVO_RELEASED + ((brk_pct >> 8) * SERVO_SPAN) / PCT_FULL);
      r.braking = 1'b1;
    end else begin
      err = int'(tgt) - int'(meas);
      if (err > ERR_MAX) err = ERR_MAX;
      if (err < ERR_MIN) err = ERR_MIN;
      if (err <= 0) begin
        integ_sum = 0;
      end else begin
        acc = longint'(integ_sum) + ((longint'(err) * longint'(sample_period)) >>> 8);
        if (acc > SUM_MAX) acc = SUM_MAX;
        integ_sum = int'(acc);
        derr = err - prev_err;
        drive_sum = longint'(prop_gain) * err * 256
                  + longint'(integ_gain) * integ_sum
                  + longint'(deriv_gain) * derr * 4096;
        prev_err = err;
        if (drive_sum > 0) begin
          drive_sum = drive_sum >>> 20;
          thr = (drive_sum > longint'(THROTTLE_FULL)) ? THROTTLE_FULL : int'(drive_sum);
        end
      end
    end
    r.throttle_pct  = thr[14:0];
    r.brake_echo    = brk;
    r.dac_high_code = dac_code_for(thr, DAC_DEN_HIGH);
    r.dac_low_code  = dac_code_for(thr, DAC_DEN_LOW);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    drive_beat_t want;
    if (rst) begin
      prop_gain     = PROP_GAIN_RST;
      integ_gain    = INTEG_GAIN_RST;
      deriv_gain    = DERIV_GAIN_RST;
      sample_period = SAMPLE_PERIOD_RST;
      integ_sum     = 0;
      prev_err      = 0;
      mismatches    = 0;
      drive_beats_due.delete();
    end else begin
      // retire the oldest prediction first: a result never belongs to a beat taken now
      if (drive.valid && drive.ready) begin
        if (drive_beats_due.size() == 0) begin
          $error("drive beat with no prediction pending");
          mismatches++;
        end else begin
          want = drive_beats_due.pop_front();
          check_field("throttle_pct", 32'(want.throttle_pct), 32'(drive.throttle_pct));
          check_field("brake_echo", 32'(want.brake_echo), 32'(drive.brake_echo));
          check_field("dac_high_code", 32'(want.dac_high_code), 32'(drive.dac_high_code));
          check_field("dac_low_code", 32'(want.dac_low_code), 32'(drive.dac_low_code));
          check_field("servo_angle", 32'(want.servo_angle), 32'(drive.servo_angle));
          check_field("braking", 32'(want.braking), 32'(drive.braking));
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_PROP_GAIN:     prop_gain     = cfg_data;
          REG_INTEG_GAIN:    integ_gain    = cfg_data;
          REG_DERIV_GAIN:    deriv_gain    = cfg_data;
          REG_SAMPLE_PERIOD: sample_period = cfg_data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        drive_beats_due.push_back(control_step(cmd.target_speed, cmd.measured_speed,
                                               cmd.brake_request));
    end
    beats_pending <= drive_beats_due.size();
  end

endmodule

// ===== tb/speed_pid_throttle_brake_step_core_tb.sv =====
module speed_pid_throttle_brake_step_core_tb;
  import spd_pid_pkg::*;

  // Quiet-cycle limit: several times the worst of the long receiver hold-off,
  // a PID beat, a sender gap and the final settle.
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 40;
  localparam int SAT_BEATS   = 270;
  localparam int RAND_BEATS  = 150;
  localparam int N_PHASES    = 7;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC} rx_mode_e;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int beats_pending;
  int burst_left;
  int quiet_cycles = 0;
  int hold_asked   = 0;
  int hold_served  = 0;

  spd_pid_cmd_if   cmd_ch();
  spd_pid_drive_if drive_ch();

  speed_pid_throttle_brake_step_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .drive     (drive_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  speed_pid_throttle_brake_step_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .drive         (drive_ch),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .beats_pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles in which no beat and no register write moves.
  always @(posedge clk) begin
    if (rst || cfg_wen || (cmd_ch.valid && cmd_ch.ready) || (drive_ch.valid && drive_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: switch between always-ready, coin-flip and periodic stall patterns.
  // When the stimulus asks for a long hold-off, drop ready and count it out here.
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_served != hold_asked) begin
        drive_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_served++;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_OPEN: drive_ch.ready <= 1'b1;
          RX_COIN: drive_ch.ready <= 1'($urandom_range(0, 1));
          default: drive_ch.ready <= (tick % 7) > 2;
        endcase
      end
    end
  end

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Brake command that keeps the PID path: zero or negative.
  function automatic logic signed [15:0] no_brake();
    if ($urandom_range(0, 3) == 0) return 16'sd0;
    return 16'(-int'($urandom_range(0, 32768)));
  endfunction

  // Error magnitude on a few scales so small and saturating errors both show up.
  function automatic int rand_delta();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 16);
      1:       return $urandom_range(1, 256);
      2:       return $urandom_range(1, 4096);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  // Offer one cmd beat and hold it until taken. The sender works in bursts;
  // at the start of a burst drop valid for a random gap.
  task automatic send_cmd(input logic signed [15:0] tgt, input logic signed [15:0] meas,
                          input logic signed [15:0] brk);
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(5, 20)) @(posedge clk);
      else
        repeat ($urandom_range(1, 3)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd_ch.valid          <= 1'b1;
    cmd_ch.target_speed   <= tgt;
    cmd_ch.measured_speed <= meas;
    cmd_ch.brake_request  <= brk;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted drive beat has come back.
  // The checker's count is registered, so wait for an edge before looking at it.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers on back-to-back edges; only legal while idle.
  task automatic load_gains(input logic [15:0] pg, input logic [15:0] ig,
                            input logic [15:0] dg, input logic [15:0] sp);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= pg;
    @(posedge clk);
    cfg_index <= REG_INTEG_GAIN;
    cfg_data  <= ig;
    @(posedge clk);
    cfg_index <= REG_DERIV_GAIN;
    cfg_data  <= dg;
    @(posedge clk);
    cfg_index <= REG_SAMPLE_PERIOD;
    cfg_data  <= sp;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Random traffic, mostly runs of positive error so the integrator and the
  // derivative term actually build up; the rest is braking, clearing and noise.
  task automatic random_traffic(input int n_beats);
    int sent;
    int kind;
    int len;
    int i;
    logic signed [15:0] tgt, meas, brk;
    sent = 0;
    while (sent < n_beats) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(2, 30);
        for (i = 0; i < len; i++) begin
          meas = 16'($urandom());
          tgt  = clip16(int'(meas) + rand_delta());
          send_cmd(tgt, meas, no_brake());
        end
      end else if (kind < 70) begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0)
            brk = 16'($urandom_range(25601, 32767));
          else
            brk = 16'($urandom_range(1, 25600));
          send_cmd(16'($urandom()), 16'($urandom()), brk);
        end
      end else if (kind < 85) begin
        len = 1;
        meas = 16'($urandom());
        tgt  = clip16(int'(meas) - int'($urandom_range(0, 4096)));
        send_cmd(tgt, meas, no_brake());
      end else begin
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++)
          send_cmd(16'($urandom()), 16'($urandom()), 16'($urandom()));
      end
      sent += len;
    end
  endtask

  initial begin
    int ph;
    int i;
    rst                   <= 1'b1;
    cfg_wen               <= 1'b0;
    cfg_index             <= REG_PROP_GAIN;
    cfg_data              <= '0;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.target_speed   <= '0;
    cmd_ch.measured_speed <= '0;
    cmd_ch.brake_request  <= '0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats on the reset register values.
    send_cmd(16'sd0, 16'sd0, 16'sd25600);          // full brake
    send_cmd(16'sd0, 16'sd0, 16'sh7FFF);           // brake above 100 %, clamp
    send_cmd(16'sd0, 16'sd0, 16'sd1);              // smallest brake
    send_cmd(16'sd0, 16'sd0, 16'sd12800);          // half brake
    send_cmd(16'sd0, 16'sd0, 16'sd25599);          // just under full brake
    send_cmd(16'sh7FFF, 16'sh8000, 16'sd0);        // error saturates high, brake at zero
    send_cmd(16'sh7FFF, 16'sh8000, 16'sh8000);     // integral keeps growing
    send_cmd(16'sd256, 16'sd0, -16'sd1);
    send_cmd(16'sd1, 16'sd0, -16'sd256);           // smallest positive error
    send_cmd(16'sd0, 16'sd0, 16'sd0);              // zero error clears the integral
    send_cmd(16'sh8000, 16'sh7FFF, 16'sh8000);     // error saturates low
    send_cmd(16'sd100, 16'sd200, 16'sd0);
    send_cmd(16'sd5000, 16'sd4000, 16'sd0);
    send_cmd(16'sd5000, 16'sd4999, 16'sd0);
    send_cmd(16'sh8000, 16'sh8000, 16'sd25600);    // brake with extreme speeds
    send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh8000);     // zero error at the top of range
    send_cmd(16'sd12800, 16'sd0, 16'sd0);
    send_cmd(16'sh7FFF, 16'sd0, 16'sd0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: load_gains(16'd0, 16'd0, 16'd0, 16'd0);                // all zero, no integration
        1: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);    // all at maximum
        2: load_gains(16'd0, 16'd1, 16'd0, 16'hFFFF);             // drive the integral to its limit
        3: load_gains(PROP_GAIN_RST, INTEG_GAIN_RST, 16'd300, 16'd1);
        default:
          load_gains(16'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                     16'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                     16'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                     16'($urandom_range(1, 65535) >> $urandom_range(0, 8)));
      endcase
      // Hold the receiver off for a long stretch so the block fills and stalls cmd.
      if (ph == 1 || ph == 4) hold_asked++;
      if (ph == 2) begin
        for (i = 0; i < SAT_BEATS; i++)
          send_cmd(16'sh7FFF, 16'(-int'($urandom_range(30000, 32768))), no_brake());
      end else begin
        random_traffic(RAND_BEATS);
      end
    end

    drain();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
